### hw/rtl/glyph_to_lcd_pixel_stream_unit_assert.svh
// assertion helpers shared by the checker file
// both expect clk and arst_n in scope
`ifndef GLYPH_TO_LCD_PIXEL_STREAM_UNIT_ASSERT_SVH
`define GLYPH_TO_LCD_PIXEL_STREAM_UNIT_ASSERT_SVH

// same-cycle implication
`define GLCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/glcd_pkg.sv
`timescale 1ns / 1ps
package glcd_pkg;

	localparam int unsigned GLYPH_BITS  = 45;
	localparam int unsigned BIT_W       = 13;
	localparam int unsigned FONT_WORDS  = 134;
	localparam int unsigned FONT_AW     = 8;
	localparam int unsigned STEP_W      = 6;

	localparam logic [7:0] FIRST_CODE = 8'd32;
	localparam logic [7:0] LAST_CODE  = 8'd126;

	localparam logic [7:0] CMD_COLS  = 8'h2A;
	localparam logic [7:0] CMD_ROWS  = 8'h2B;
	localparam logic [7:0] CMD_WRITE = 8'h2C;

	localparam logic [7:0] COL_SPAN = 8'd4;
	localparam logic [7:0] ROW_SPAN = 8'd8;

	localparam logic [1:0] KIND_CMD   = 2'd0;
	localparam logic [1:0] KIND_DATA  = 2'd1;
	localparam logic [1:0] KIND_PIXEL = 2'd2;

	localparam logic [1:0] REG_FG_RED   = 2'd0;
	localparam logic [1:0] REG_FG_GREEN = 2'd1;
	localparam logic [1:0] REG_FG_BLUE  = 2'd2;

	// sequencer steps: window commands, then pixels
	localparam logic [STEP_W-1:0] STEP_CMD_COLS    = 6'd0;
	localparam logic [STEP_W-1:0] STEP_COL_START   = 6'd1;
	localparam logic [STEP_W-1:0] STEP_COL_END     = 6'd2;
	localparam logic [STEP_W-1:0] STEP_CMD_ROWS    = 6'd3;
	localparam logic [STEP_W-1:0] STEP_ROW_START   = 6'd4;
	localparam logic [STEP_W-1:0] STEP_ROW_END     = 6'd5;
	localparam logic [STEP_W-1:0] STEP_CMD_WRITE   = 6'd6;
	localparam logic [STEP_W-1:0] STEP_FIRST_PIXEL = 6'd7;
	localparam logic [STEP_W-1:0] STEP_LAST        = 6'd51;

	typedef struct packed {
		logic             blank;
		logic [BIT_W-1:0] base;
		logic [7:0]       col;
		logic [7:0]       col_end;
		logic [7:0]       row;
		logic [7:0]       row_end;
	} glcd_entry_t;

	// packed 5x9 font, msb first, 45 bits per glyph from space upward
	localparam logic [31:0] FONT_ROM [0:FONT_WORDS-1] = '{
		32'h00000000, 32'h00010842, 32'h10040014, 32'hA0000000, 32'h00057D4A,
		32'hFA80023E, 32'h8E2F8800, 32'h02222222, 32'h000114A2, 32'h2B268004,
		32'h22000000, 32'h00110842, 32'h10820208, 32'h42108440, 32'h004ABAA4,
		32'h00000213, 32'hE4200000, 32'h00000108, 32'h800000F8, 32'h00000000,
		32'h00000200, 32'h00088888, 32'h00007467, 32'h5CC5C001, 32'h1842108E,
		32'h001D1099, 32'h10F800E8, 32'h84C18B80, 32'h011952F8, 32'h84007E1E,
		32'h0862E001, 32'hD0F46317, 32'h001F0888, 32'h84200074, 32'h62E8C5C0,
		32'h03A318BC, 32'h2E000002, 32'h00040000, 32'h00100021, 32'h10000888,
		32'h20800000, 32'h1F07C000, 32'h00082088, 32'h80000E88, 32'h44401000,
		32'h03A35BC1, 32'hC0011518, 32'hFE31003D, 32'h18FA31F0, 32'h00E8C210,
		32'h8B800E4A, 32'h318CB800, 32'h7E10F421, 32'hF003F087, 32'hA108000E,
		32'h8C2138B8, 32'h008C63F8, 32'hC6200388, 32'h42108E00, 32'h1E210852,
		32'h60011953, 32'h14944008, 32'h4210843E, 32'h004775AC, 32'h63100239,
		32'hAD6B3880, 32'h0E8C6318, 32'hB800F463, 32'h1F420003, 32'hA318D64D,
		32'h003D18C7, 32'hD18800E8, 32'hC1C18B80, 32'h0F908421, 32'h08004631,
		32'h8C62E002, 32'h318A9442, 32'h00118C6B, 32'h5528008C, 32'h54454620,
		32'h04631510, 32'h84003E11, 32'h1110F800, 32'h62108421, 32'h0C004104,
		32'h10400030, 32'h84210846, 32'h008A8800, 32'h00000000, 32'h00007C00,
		32'h21040000, 32'h000000C1, 32'h3A4E0021, 32'h0E4A52E0, 32'h00003A10,
		32'h83800109, 32'hD2949C00, 32'h000C9720, 32'hE000C847, 32'h10840000,
		32'h03252938, 32'h4C843929, 32'h4A400100, 32'h42108400, 32'h08021084,
		32'h2111084A, 32'h98A48002, 32'h10842104, 32'h00001AAD, 32'h6B500000,
		32'hE4A52900, 32'h00032529, 32'h30000039, 32'h294B9080, 32'h00E94A4E,
		32'h10800B62, 32'h10800000, 32'h320C1700, 32'h04238842, 32'h08000012,
		32'h94A4E000, 32'h0094A544, 32'h00000463, 32'h5AA80000, 32'h22A22A20,
		32'h0001294A, 32'h4E13000F, 32'h1110F000, 32'h22110421, 32'h04021084,
		32'h21080020, 32'h84110844, 32'h01540000, 32'h00000000
	};

endpackage

### hw/rtl/glcd_front.sv
`timescale 1ns / 1ps
module glcd_front (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // char_code[7:0], column[15:8], row[23:16]
	input  logic                 q_full,
	output logic                 push,
	output glcd_pkg::glcd_entry_t entry
);
	import glcd_pkg::*;

	logic [7:0] code;
	logic [6:0] glyph;

	assign code     = s_tdata[7:0];
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	assign glyph = 7'(code - FIRST_CODE);

	always_comb begin
		entry.blank   = (code < FIRST_CODE) || (code > LAST_CODE);
		// first bit of the glyph in the font rom
		entry.base    = entry.blank ? '0 :
			BIT_W'(BIT_W'(glyph) * BIT_W'(GLYPH_BITS));
		entry.col     = s_tdata[15:8];
		entry.col_end = s_tdata[15:8] + COL_SPAN;
		entry.row     = s_tdata[23:16];
		entry.row_end = s_tdata[23:16] + ROW_SPAN;
	end

endmodule

### hw/rtl/glcd_queue.sv
`timescale 1ns / 1ps
module glcd_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  glcd_pkg::glcd_entry_t wr_entry,
	output logic                  full,
	input  logic                  pop,
	output logic                  rd_valid,
	output glcd_pkg::glcd_entry_t rd_entry
);
	import glcd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

	glcd_entry_t   mem_q [0:DEPTH-1];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_entry = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/glcd_back.sv
`timescale 1ns / 1ps
module glcd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	input  logic                  q_valid,
	input  glcd_pkg::glcd_entry_t q_entry,
	output logic                  pop,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,
	output logic [1:0]            m_tuser,
	output logic                  m_tlast
);
	import glcd_pkg::*;

	logic [7:0]          fg_red_q;
	logic [7:0]          fg_green_q;
	logic [7:0]          fg_blue_q;
	logic [STEP_W-1:0]   step_q;
	logic                valid_q;
	logic [15:0]         word_q;
	logic [1:0]          kind_q;
	logic                last_q;

	logic                load;
	logic [STEP_W-1:0]   pix_ofs;
	logic [BIT_W-1:0]    bit_idx;
	logic [31:0]         font_word;
	logic                glyph_bit;
	logic [15:0]         fg;
	logic [15:0]         word_d;
	logic [1:0]          kind_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_red_q   <= '0;
			fg_green_q <= '0;
			fg_blue_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FG_RED:   fg_red_q   <= cfg_data;
				REG_FG_GREEN: fg_green_q <= cfg_data;
				REG_FG_BLUE:  fg_blue_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fg = {fg_red_q[7:3], fg_green_q[7:2], fg_blue_q[7:3]};

	// output register takes a new word whenever a queue entry waits and it is empty or being drained
	assign load = q_valid && (!valid_q || m_tready);
	assign pop  = load && (step_q == STEP_LAST);

	assign pix_ofs   = step_q - STEP_FIRST_PIXEL;
	assign bit_idx   = q_entry.base + BIT_W'(pix_ofs);
	assign font_word = FONT_ROM[bit_idx[BIT_W-1:5]];
	assign glyph_bit = font_word[~bit_idx[4:0]];

	always_comb begin
		word_d = '0;
		kind_d = KIND_DATA;
		case (step_q)
			STEP_CMD_COLS: begin
				word_d = {8'h00, CMD_COLS};
				kind_d = KIND_CMD;
			end
			STEP_COL_START: word_d = {8'h00, q_entry.col};
			STEP_COL_END:   word_d = {8'h00, q_entry.col_end};
			STEP_CMD_ROWS: begin
				word_d = {8'h00, CMD_ROWS};
				kind_d = KIND_CMD;
			end
			STEP_ROW_START: word_d = {8'h00, q_entry.row};
			STEP_ROW_END:   word_d = {8'h00, q_entry.row_end};
			STEP_CMD_WRITE: begin
				word_d = {8'h00, CMD_WRITE};
				kind_d = KIND_CMD;
			end
			default: begin
				word_d = (glyph_bit && !q_entry.blank) ? fg : 16'h0000;
				kind_d = KIND_PIXEL;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= word_d;
			kind_q <= kind_d;
			last_q <= (step_q == STEP_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			step_q  <= STEP_CMD_COLS;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				step_q  <= (step_q == STEP_LAST) ? STEP_CMD_COLS : step_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = word_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

endmodule

### hw/rtl/glyph_to_lcd_pixel_stream_unit.sv
`timescale 1ns / 1ps
// Character generator for an RGB565 display controller, 5x9 font.
// Input stream: one item per character, tdata = {row, column, char_code}.
// Output stream: 52 items per character. The first seven set the window:
// command 0x2A, column, column+4, command 0x2B, row, row+8, command 0x2C
// (data bytes wrap at 256). Then 45 pixels follow row-major, foreground
// color where the glyph bit is set and black otherwise; tlast marks the
// final pixel. tuser gives the kind: 0 command, 1 data, 2 pixel.
// Codes outside 32..126 give 45 black pixels.
// Foreground color is written through cfg_we/cfg_index/cfg_data
// (0 red, 1 green, 2 blue); the user must do so only while no character
// is in flight; the block itself does not enforce this.
// With the sequencer idle, an input item is stored in the queue, then
// its first word is registered in the output register. The sequencer
// gives one output word per cycle while the receiver is ready; a queue
// of QUEUE_DEPTH characters lets input be taken while the sequencer runs.
// Reset clears the colors to black, empties the queue and the output.
// A stalled receiver holds the current word; the sequencer waits, and
// input is refused only once the queue is full.
module glyph_to_lcd_pixel_stream_unit #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], column[15:8], row[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // word[15:0]
	output logic [1:0]  m_tuser,   // word_kind[1:0]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import glcd_pkg::*;

	logic        push;
	logic        q_full;
	logic        q_valid;
	logic        pop;
	glcd_entry_t wr_entry;
	glcd_entry_t rd_entry;

	glcd_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.entry    (wr_entry)
	);

	glcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_entry (rd_entry)
	);

	glcd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_entry   (rd_entry),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

### hw/rtl/glcd_checker.sv
`timescale 1ns / 1ps
`include "glyph_to_lcd_pixel_stream_unit_assert.svh"
module glcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import glcd_pkg::*;

	// position of the next output item within its character
	logic [STEP_W-1:0] pos_q;
	logic              out_take;

	assign out_take = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_take) begin
			pos_q <= m_tlast ? '0 : pos_q + 1'b1;
		end
	end

	`GLCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"stalled output item changed")

	`GLCD_ASSERT_NOW(a_first_word, m_tvalid && (pos_q == '0),
		(m_tuser == KIND_CMD) && (m_tdata == {8'h00, CMD_COLS}),
		"character does not open with the column command")

	`GLCD_ASSERT_NOW(a_last_pos, m_tvalid && m_tlast,
		(pos_q == STEP_LAST) && (m_tuser == KIND_PIXEL),
		"last flag off the final pixel")

	`GLCD_ASSERT_NOW(a_pixel_pos, m_tvalid && (m_tuser == KIND_PIXEL),
		pos_q >= STEP_FIRST_PIXEL,
		"pixel before the window commands finished")

endmodule

bind glyph_to_lcd_pixel_stream_unit glcd_checker u_glcd_checker (.*);
